>>> hdl/tbld_pkg.sv
// Package for the text screen line drawer: word types, box-drawing
// connection and glyph tables, and default sizes. No dependencies.
package tbld_pkg;

   localparam int ROWS_DEF    = 64;
   localparam int COLS_DEF    = 128;
   localparam int MAX_LEN_DEF = 255;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_DRAW   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] CSR_LAST_ROW    = 2'd0;
   localparam logic [1:0] CSR_LAST_COL    = 2'd1;
   localparam logic [1:0] CSR_BLOCK_CHAR  = 2'd2;
   localparam logic [1:0] CSR_FORCE_BLOCK = 2'd3;

   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] ATTR_DEF  = 8'd7;
   localparam logic [7:0] BOX_FIRST = 8'd179;
   localparam logic [7:0] BOX_LAST  = 8'd218;
   localparam logic [7:0] CH_H1 = 8'd196;
   localparam logic [7:0] CH_H2 = 8'd205;
   localparam logic [7:0] CH_V1 = 8'd179;
   localparam logic [7:0] CH_V2 = 8'd186;

   localparam logic [5:0] CN = 6'd1;
   localparam logic [5:0] CS = 6'd2;
   localparam logic [5:0] CE = 6'd4;
   localparam logic [5:0] CW = 6'd8;
   localparam logic [5:0] DH = 6'd16;
   localparam logic [5:0] DV = 6'd32;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] row;
      logic [6:0] column;
      logic [7:0] length;
      logic [1:0] line_width;
      logic       vertical;
      logic       connect;
      logic [7:0] char_in;
      logic [7:0] attr_in;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [7:0] attr_out;
      logic [7:0] cells_drawn;
      logic       status;
   } rsp_type;

   localparam logic [5:0] LINK_OF [40] = '{
      CN|CS, CN|CS|CW, CN|CS|CW|DH, CN|CS|CW|DV, CS|CW|DV, CS|CW|DH,
      CN|CS|CW|DH|DV, CN|CS|DV, CW|CS|DH|DV, CN|CW|DH|DV, CN|CW|DV, CN|CW|DH,
      CW|CS, CN|CE, CN|CW|CE, CW|CE|CS, CN|CS|CE, CE|CW, CN|CS|CE|CW,
      CN|CS|CE|DH, CN|CS|CE|DV, CN|CE|DH|DV, CE|CS|DH|DV, CN|CE|CW|DH|DV,
      CE|CW|CS|DH|DV, CN|CS|CE|DH|DV, CE|CW|DH, CN|CS|CE|CW|DH|DV,
      CN|CE|CW|DH, CN|CE|CW|DV, CE|CW|CS|DH, CE|CW|CS|DV, CN|CE|DV,
      CN|CE|DH, CS|CE|DH, CS|CE|DV, CN|CS|CE|CW|DV, CN|CS|CE|CW|DH,
      CN|CW, CE|CS
   };

   localparam logic [7:0] GLYPH_OF [64] = '{
      8'd32,  8'd179, 8'd179, 8'd179, 8'd196, 8'd192, 8'd218, 8'd195,
      8'd196, 8'd217, 8'd191, 8'd180, 8'd196, 8'd193, 8'd194, 8'd197,
      8'd32,  8'd179, 8'd179, 8'd179, 8'd205, 8'd212, 8'd213, 8'd198,
      8'd205, 8'd190, 8'd184, 8'd181, 8'd205, 8'd207, 8'd209, 8'd216,
      8'd32,  8'd186, 8'd186, 8'd186, 8'd196, 8'd211, 8'd214, 8'd199,
      8'd196, 8'd189, 8'd183, 8'd182, 8'd196, 8'd208, 8'd210, 8'd215,
      8'd32,  8'd186, 8'd186, 8'd186, 8'd205, 8'd200, 8'd201, 8'd204,
      8'd205, 8'd188, 8'd187, 8'd185, 8'd205, 8'd202, 8'd203, 8'd206
   };

   // {is box char, connection bits}
   function automatic logic [6:0] cell_links(input logic [7:0] ch);
      logic [6:0] res;
      res = 7'd0;
      if (ch inside {[BOX_FIRST:BOX_LAST]}) begin
         res = {1'b1, LINK_OF[6'(ch - BOX_FIRST)]};
      end
      return res;
   endfunction

endpackage

>>> hdl/text_box_line_connector_draw.sv
// Top level of the text screen line drawer: screen memory, sequencer and
// config registers. Depends on tbld_pkg.
//
// After reset the block clears all ROWS*COLS cells of the screen memory (8192 by
// default) with busy high. A cell write is answered at acceptance, a read once the
// memory has been read, and a draw makes five reads of the single memory read port
// per cell, then the write, for up to 255 cells. Each result is shown for one
// cycle on rsp_valid/rsp_data and cannot be held off by the receiver.
module text_box_line_connector_draw
   import tbld_pkg::*;
#(
   parameter int ROWS    = ROWS_DEF,
   parameter int COLS    = COLS_DEF,
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);
   localparam logic [7:0] COL_MAX = 8'(COLS - 1);
   localparam logic [7:0] LEN_MAX = 8'(MAX_LEN);
   localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

   typedef enum logic [2:0] {S_CLR, S_IDLE, S_RDR, S_DRAW, S_DONE} state_type;

   state_type     state_ff;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_v_ff;
   logic          rsp_v_in;
   logic [AW-1:0] clr_ff;
   logic [2:0]    k_ff;
   logic [7:0]    i_ff, r_ff, c_ff, len_ff;
   logic [1:0]    wid_ff;
   logic [6:0]    own_ff;
   logic [3:0]    nb_ff; // W E N S neighbor reaches this cell
   logic [5:0]    last_row_ff;
   logic [6:0]    last_col_ff;
   logic [7:0]    block_char_ff;
   logic          force_block_ff;

   logic [15:0]   mem [DEPTH];
   logic [15:0]   mem_q;
   logic          mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [15:0]   mem_wd;

   logic [7:0] bottom, right, row_in, col_in, len_cap;
   logic       accept, outside, first, last, edge_hit;
   logic [6:0] q_links;
   logic [5:0] b;
   logic [7:0] draw_ch;

   function automatic logic [AW-1:0] addr_of(input logic [7:0] r, input logic [7:0] c);
      return AW'(r * COLS + c);
   endfunction

   assign bottom  = ({2'b0, last_row_ff} < ROW_MAX) ? {2'b0, last_row_ff} : ROW_MAX;
   assign right   = ({1'b0, last_col_ff} < COL_MAX) ? {1'b0, last_col_ff} : COL_MAX;
   assign row_in  = {2'b0, req_data.row};
   assign col_in  = {1'b0, req_data.column};
   assign len_cap = (req_data.length > LEN_MAX) ? LEN_MAX : req_data.length;
   assign outside = (row_in > bottom) || (col_in > right);
   assign accept  = start && !busy;
   assign busy    = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // words answered right at acceptance, plus the ends of read and draw
   assign rsp_v_in = (state_ff == S_RDR) || (state_ff == S_DONE) ||
                     (accept && ((req_data.mode == MODE_UNUSED) || outside ||
                                 (req_data.mode == MODE_WRITE) ||
                                 ((req_data.mode == MODE_DRAW) && (len_cap == 8'd0))));

   assign first    = (i_ff == 8'd0);
   assign last     = (i_ff == len_ff - 8'd1);
   assign edge_hit = req_ff.vertical ? (r_ff == bottom) : (c_ff == right);
   assign q_links  = cell_links(mem_q[15:8]);

   // merged connections of the current cell, and the character to write there
   always_comb begin
      b = own_ff[5:0];
      if (!req_ff.vertical) begin
         b = (b & ~DH) | CW | CE | ((wid_ff == 2'd1) ? 6'd0 : DH);
      end else begin
         b = (b & ~DV) | CN | CS | ((wid_ff == 2'd1) ? 6'd0 : DV);
      end
      if (first || req_ff.vertical) begin
         b = (b & ~CW) | (nb_ff[3] ? CW : 6'd0);
      end
      if (last || req_ff.vertical) begin
         b = (b & ~CE) | (nb_ff[2] ? CE : 6'd0);
      end
      if (!req_ff.vertical || first) begin
         b = (b & ~CN) | (nb_ff[1] ? CN : 6'd0);
      end
      if (!req_ff.vertical || last) begin
         b = (b & ~CS) | (nb_ff[0] ? CS : 6'd0);
      end
      if (wid_ff == 2'd0) begin
         draw_ch = block_char_ff;
      end else if ((!req_ff.connect && !first && !last) || !own_ff[6]) begin
         if (!req_ff.vertical) draw_ch = (wid_ff == 2'd1) ? CH_H1 : CH_H2;
         else                  draw_ch = (wid_ff == 2'd1) ? CH_V1 : CH_V2;
      end else begin
         draw_ch = GLYPH_OF[b];
      end
   end

   // memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_of(r_ff, c_ff);
      mem_wd = {draw_ch, req_ff.attr_in};
      mem_ra = addr_of(r_ff, c_ff);
      case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = {CH_SPACE, ATTR_DEF};
         end
         S_IDLE: begin
            mem_ra = addr_of(row_in, col_in);
            mem_wa = addr_of(row_in, col_in);
            mem_wd = {req_data.char_in, req_data.attr_in};
            mem_we = accept && !outside && (req_data.mode == MODE_WRITE);
         end
         S_DRAW: begin
            case (k_ff)
               3'd1: if (c_ff > 8'd0)  mem_ra = addr_of(r_ff, c_ff - 8'd1);
               3'd2: if (c_ff < right) mem_ra = addr_of(r_ff, c_ff + 8'd1);
               3'd3: if (r_ff > 8'd0)  mem_ra = addr_of(r_ff - 8'd1, c_ff);
               3'd4: if (r_ff < bottom) mem_ra = addr_of(r_ff + 8'd1, c_ff);
               default: ;
            endcase
            mem_we = (k_ff == 3'd6);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_row_ff    <= 6'd24;
         last_col_ff    <= 7'd79;
         block_char_ff  <= 8'd219;
         force_block_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LAST_ROW:    last_row_ff    <= csr_wdata[5:0];
            CSR_LAST_COL:    last_col_ff    <= csr_wdata[6:0];
            CSR_BLOCK_CHAR:  block_char_ff  <= csr_wdata;
            CSR_FORCE_BLOCK: force_block_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         rsp_v_ff <= 1'b0;
         k_ff     <= 3'd0;
      end else begin
         rsp_v_ff <= rsp_v_in;
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == ADDR_LAST) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  rsp_ff <= '{char_out: 8'd0, attr_out: 8'd0, cells_drawn: 8'd0,
                              status: (req_data.mode != MODE_UNUSED) && outside};
                  r_ff   <= row_in;
                  c_ff   <= col_in;
                  len_ff <= len_cap;
                  wid_ff <= force_block_ff ? 2'd0 : req_data.line_width;
                  i_ff   <= 8'd0;
                  k_ff   <= 3'd0;
                  if ((req_data.mode != MODE_UNUSED) && !outside) begin
                     if (req_data.mode == MODE_READ) begin
                        state_ff <= S_RDR;
                     end else if ((req_data.mode == MODE_DRAW) && (len_cap != 8'd0)) begin
                        state_ff <= S_DRAW;
                     end
                  end
               end
            end
            S_RDR: begin
               rsp_ff.char_out <= mem_q[15:8];
               rsp_ff.attr_out <= mem_q[7:0];
               state_ff <= S_IDLE;
            end
            S_DRAW: begin
               // read k issued at step k, its data captured at step k+1
               k_ff <= (k_ff == 3'd6) ? 3'd0 : k_ff + 3'd1;
               case (k_ff)
                  3'd1: own_ff   <= q_links;
                  3'd2: nb_ff[3] <= (c_ff > 8'd0)   && q_links[6] && |(q_links[5:0] & CE);
                  3'd3: nb_ff[2] <= (c_ff < right)  && q_links[6] && |(q_links[5:0] & CW);
                  3'd4: nb_ff[1] <= (r_ff > 8'd0)   && q_links[6] && |(q_links[5:0] & CS);
                  3'd5: nb_ff[0] <= (r_ff < bottom) && q_links[6] && |(q_links[5:0] & CN);
                  3'd6: begin
                     i_ff <= i_ff + 8'd1;
                     if (last || edge_hit) begin
                        rsp_ff.cells_drawn <= i_ff + 8'd1;
                        state_ff <= S_DONE;
                     end else if (req_ff.vertical) begin
                        r_ff <= r_ff + 8'd1;
                     end else begin
                        c_ff <= c_ff + 8'd1;
                     end
                  end
                  default: ;
               endcase
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/tbld_checker.sv
// Port-level checks for the text screen line drawer, bound to the top level.
// Depends on tbld_pkg.
module tbld_checker
   import tbld_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // screen clear runs right after reset
   a_clear_busy: assert property (@(posedge clock) $past(reset) && !reset |-> busy)
      else $error("not busy after reset");

   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.mode == MODE_UNUSED |=> rsp_valid && rsp_data == '0)
      else $error("unused mode gave nonzero word");

   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.mode == MODE_WRITE |=> rsp_valid && rsp_data.cells_drawn == 8'd0)
      else $error("write response missing");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.cells_drawn == 8'd0 && rsp_data.char_out == 8'd0)
      else $error("error word carries data");

endmodule

bind text_box_line_connector_draw tbld_checker u_tbld_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
